@@ rtl/tcsv_pkg.sv @@
package tcsv_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_FETCH,
    S_VOTE,
    S_EMIT,
    S_DRAIN
  } state_t;

  // Which of the three copies an access goes to.
  typedef enum logic [1:0] {
    COPY_MAIN,
    COPY_B1,
    COPY_B2
  } copy_t;

  // Item action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Result kind codes.
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Value of an erased byte.
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

endpackage

@@ rtl/tcsv_ram.sv @@
module tcsv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/triple_copy_store_with_vote.sv @@
// Channel   Handshake             Payload
// request   req_valid, req_stall  action, address, data, count
// response  rsp_valid, rsp_stall  kind, read_byte, status, last
//
// A write is accepted, stores the main copy and the two backups in turn, and then
// waits until its acknowledge is taken. A read of n bytes fetches each byte from
// the three copies in turn, as the store has a single read port, then votes and
// hands out its bytes, one per cycle while the response is not stalled.
// After reset the store is set to 0xFF by a sweep of all STORE_DEPTH addresses,
// in which no item is taken. A stalled response holds the whole sequencer.
module triple_copy_store_with_vote #(
  parameter int STORE_DEPTH = 512,
  parameter int COPY_STRIDE = 168,
  parameter int MAX_RUN     = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       action,
  input  logic [8:0] address,
  input  logic [7:0] data,
  input  logic [3:0] count,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic       kind,
  output logic [7:0] read_byte,
  output logic [1:0] status,
  output logic       last
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int IW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [AW-1:0] OFS_B1 = AW'(COPY_STRIDE);
  localparam logic [AW-1:0] OFS_B2 = AW'(2 * COPY_STRIDE);

  tcsv_pkg::state_t state, state_next;
  tcsv_pkg::copy_t  copy, rd_copy;

  logic [AW-1:0] clr_addr;
  logic [8:0]    base;
  logic [7:0]    wdata;
  logic [IW-1:0] idx, last_idx, rd_idx, last_idx_in;
  logic          rd_pending;
  logic          m1, m2, b12;
  logic [7:0]    main_buf [MAX_RUN];
  logic [7:0]    b1_buf [MAX_RUN];

  logic          req_accept, in_range;
  logic [AW-1:0] copy_ofs, acc_addr;
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data, ram_rd_data;
  logic          use_b1, no_match;

  logic          ld;
  logic          ld_kind, ld_last;
  logic [7:0]    ld_byte;
  logic [1:0]    ld_status;

  assign req_stall  = (state != tcsv_pkg::S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign in_range   = (address < 9'(COPY_STRIDE));

  // Saturate the run length to 1..MAX_RUN and keep its last index.
  always_comb begin
    if (count == 4'd0) begin
      last_idx_in = '0;
    end else if (count > 4'(MAX_RUN)) begin
      last_idx_in = IW'(MAX_RUN - 1);
    end else begin
      last_idx_in = IW'(count - 4'd1);
    end
  end

  // Shared address unit: base plus byte offset plus copy offset.
  always_comb begin
    case (copy)
      tcsv_pkg::COPY_MAIN: copy_ofs = '0;
      tcsv_pkg::COPY_B1:   copy_ofs = OFS_B1;
      tcsv_pkg::COPY_B2:   copy_ofs = OFS_B2;
      default:             copy_ofs = '0;
    endcase
    acc_addr = AW'(base) + AW'(idx) + copy_ofs;
  end

  // Store port selection: erase sweep or copy writes, and run fetches.
  always_comb begin
    ram_wr_en   = (state == tcsv_pkg::S_CLEAR) || (state == tcsv_pkg::S_WRITE);
    ram_wr_addr = (state == tcsv_pkg::S_CLEAR) ? clr_addr : acc_addr;
    ram_wr_data = (state == tcsv_pkg::S_CLEAR) ? tcsv_pkg::ERASED_BYTE : wdata;
    ram_rd_en   = (state == tcsv_pkg::S_FETCH);
  end

  tcsv_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (acc_addr),
    .rd_data (ram_rd_data)
  );

  // Vote outcome from the whole-run compare flags.
  assign no_match = !(m1 || m2);
  assign use_b1   = no_match && b12;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcsv_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and loading of the response register.
  always_comb begin
    state_next = state;
    ld         = 1'b0;
    ld_kind    = tcsv_pkg::KIND_ACK;
    ld_byte    = '0;
    ld_status  = tcsv_pkg::ST_OK;
    ld_last    = 1'b1;
    case (state)
      tcsv_pkg::S_CLEAR: begin
        if (clr_addr == AW'(STORE_DEPTH - 1)) begin
          state_next = tcsv_pkg::S_IDLE;
        end
      end
      tcsv_pkg::S_IDLE: begin
        if (req_accept) begin
          if (!in_range) begin
            ld         = 1'b1;
            ld_kind    = action;
            ld_status  = tcsv_pkg::ST_RANGE;
            state_next = tcsv_pkg::S_DRAIN;
          end else if (action == tcsv_pkg::ACT_WRITE) begin
            state_next = tcsv_pkg::S_WRITE;
          end else begin
            state_next = tcsv_pkg::S_FETCH;
          end
        end
      end
      tcsv_pkg::S_WRITE: begin
        if (copy == tcsv_pkg::COPY_B2) begin
          ld         = 1'b1;
          state_next = tcsv_pkg::S_DRAIN;
        end
      end
      tcsv_pkg::S_FETCH: begin
        if ((copy == tcsv_pkg::COPY_B2) && (idx == last_idx)) begin
          state_next = tcsv_pkg::S_VOTE;
        end
      end
      tcsv_pkg::S_VOTE: begin
        state_next = tcsv_pkg::S_EMIT;
      end
      tcsv_pkg::S_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          ld        = 1'b1;
          ld_kind   = tcsv_pkg::KIND_READ;
          ld_byte   = use_b1 ? b1_buf[idx] : main_buf[idx];
          ld_status = (no_match && !b12) ? tcsv_pkg::ST_MISMATCH : tcsv_pkg::ST_OK;
          ld_last   = (idx == last_idx);
          if (idx == last_idx) begin
            state_next = tcsv_pkg::S_DRAIN;
          end
        end
      end
      tcsv_pkg::S_DRAIN: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = tcsv_pkg::S_IDLE;
        end
      end
      default: state_next = tcsv_pkg::S_CLEAR;
    endcase
  end

  // Erase sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == tcsv_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Item fields and the copy and byte counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      copy <= tcsv_pkg::COPY_MAIN;
      idx  <= '0;
    end else if (req_accept) begin
      base     <= address;
      wdata    <= data;
      last_idx <= last_idx_in;
      copy     <= tcsv_pkg::COPY_MAIN;
      idx      <= '0;
    end else if (state == tcsv_pkg::S_WRITE || state == tcsv_pkg::S_FETCH) begin
      case (copy)
        tcsv_pkg::COPY_MAIN: copy <= tcsv_pkg::COPY_B1;
        tcsv_pkg::COPY_B1:   copy <= tcsv_pkg::COPY_B2;
        default: begin
          copy <= tcsv_pkg::COPY_MAIN;
          idx  <= (idx == last_idx) ? '0 : idx + IW'(1);
        end
      endcase
    end else if (state == tcsv_pkg::S_EMIT && ld) begin
      idx <= idx + IW'(1);
    end
  end

  // Track the read in flight so its data is taken in the cycle after the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= ram_rd_en;
    end
    rd_copy <= copy;
    rd_idx  <= idx;
  end

  // Buffer the main and first backup copies and fold in the compares.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      m1  <= 1'b1;
      m2  <= 1'b1;
      b12 <= 1'b1;
    end else if (rd_pending) begin
      case (rd_copy)
        tcsv_pkg::COPY_MAIN: main_buf[rd_idx] <= ram_rd_data;
        tcsv_pkg::COPY_B1: begin
          b1_buf[rd_idx] <= ram_rd_data;
          m1 <= m1 && (ram_rd_data == main_buf[rd_idx]);
        end
        tcsv_pkg::COPY_B2: begin
          m2  <= m2 && (ram_rd_data == main_buf[rd_idx]);
          b12 <= b12 && (ram_rd_data == b1_buf[rd_idx]);
        end
        default: begin
        end
      endcase
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ld) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (ld) begin
      kind      <= ld_kind;
      read_byte <= ld_byte;
      status    <= ld_status;
      last      <= ld_last;
    end
  end

`ifndef SYNTH
  // No item is taken while a result is still waiting.
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while a response is pending");

  // Once the last result of an item is taken, the next item can come.
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && last && !rsp_stall) |=> !req_stall)
    else $error("block not ready after the last result");

  // Only reads can report that all three copies differ.
  a_mismatch_on_read: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == tcsv_pkg::ST_MISMATCH) |-> (kind == tcsv_pkg::KIND_READ))
    else $error("mismatch status on a write acknowledge");
`endif

endmodule

@@ dv/copy_vote_checker.sv @@
`timescale 1ns / 100ps

module copy_vote_checker #(
  parameter int STORE_DEPTH = 512,
  parameter int COPY_STRIDE = 168,
  parameter int MAX_RUN     = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_stall,
  input  logic       action,
  input  logic [8:0] address,
  input  logic [7:0] data,
  input  logic [3:0] count,
  input  logic       rsp_valid,
  input  logic       rsp_stall,
  input  logic       kind,
  input  logic [7:0] read_byte,
  input  logic [1:0] status,
  input  logic       last,
  output int         mismatch_count,
  output int         results_outstanding
);

  typedef struct packed {
    logic       kind;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic       last;
  } vote_result_t;

  // Image of the three-copy store and the results still owed by the block.
  logic [7:0]   store_image [STORE_DEPTH];
  vote_result_t expected_results [$];

  // Applies one accepted item to the store image and queues what it must return.
  function automatic void predict_item(logic act, logic [8:0] addr, logic [7:0] wr_byte,
                                       logic [3:0] run_req);
    logic [7:0]   copy_run [3][MAX_RUN];
    int           run_len;
    bit           main_b1;
    bit           main_b2;
    bit           b1_b2;
    int           pick;
    logic [1:0]   run_status;
    vote_result_t res;

    // An address past the protected region gives a single range result.
    if (addr > COPY_STRIDE - 1) begin
      res.kind      = (act == tcsv_pkg::ACT_WRITE) ? tcsv_pkg::KIND_ACK : tcsv_pkg::KIND_READ;
      res.read_byte = 8'h00;
      res.status    = tcsv_pkg::ST_RANGE;
      res.last      = 1'b1;
      expected_results.push_back(res);
      return;
    end

    // A write lands in all three copies and is acknowledged once.
    if (act == tcsv_pkg::ACT_WRITE) begin
      for (int c = 0; c < 3; c++)
        store_image[(addr + c * COPY_STRIDE) % STORE_DEPTH] = wr_byte;
      res.kind      = tcsv_pkg::KIND_ACK;
      res.read_byte = 8'h00;
      res.status    = tcsv_pkg::ST_OK;
      res.last      = 1'b1;
      expected_results.push_back(res);
      return;
    end

    // A zero length reads one byte; lengths past the run buffer are clipped.
    run_len = (run_req == 0) ? 1 : ((run_req > MAX_RUN) ? MAX_RUN : int'(run_req));

    // Fetch the run from all three copies.
    for (int i = 0; i < run_len; i++)
      for (int c = 0; c < 3; c++)
        copy_run[c][i] = store_image[(addr + i + c * COPY_STRIDE) % STORE_DEPTH];

    // Compare the copies as whole runs.
    main_b1 = 1'b1;
    main_b2 = 1'b1;
    b1_b2   = 1'b1;
    for (int i = 0; i < run_len; i++) begin
      if (copy_run[0][i] != copy_run[1][i]) main_b1 = 1'b0;
      if (copy_run[0][i] != copy_run[2][i]) main_b2 = 1'b0;
      if (copy_run[1][i] != copy_run[2][i]) b1_b2 = 1'b0;
    end

    // Main wins if any backup backs it, else the agreeing backups win.
    if (main_b1 || main_b2) begin
      pick       = int'(tcsv_pkg::COPY_MAIN);
      run_status = tcsv_pkg::ST_OK;
    end else if (b1_b2) begin
      pick       = int'(tcsv_pkg::COPY_B1);
      run_status = tcsv_pkg::ST_OK;
    end else begin
      pick       = int'(tcsv_pkg::COPY_MAIN);
      run_status = tcsv_pkg::ST_MISMATCH;
    end

    for (int i = 0; i < run_len; i++) begin
      res.kind      = tcsv_pkg::KIND_READ;
      res.read_byte = copy_run[pick][i];
      res.status    = run_status;
      res.last      = (i == run_len - 1);
      expected_results.push_back(res);
    end
  endfunction

  // Responses are checked before the new request is predicted in the same cycle.
  always @(posedge clk) begin : watch
    vote_result_t want;
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) store_image[i] = tcsv_pkg::ERASED_BYTE;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d read_byte %0h status %0d last %0d",
                 kind, read_byte, status, last);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
            mismatch_count++;
          end
          if (read_byte !== want.read_byte) begin
            $error("read_byte mismatch: expected %0h, actual %0h", want.read_byte, read_byte);
            mismatch_count++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            mismatch_count++;
          end
          if (last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, last);
            mismatch_count++;
          end
        end
      end
      if (req_valid && !req_stall) predict_item(action, address, data, count);
    end
    results_outstanding = expected_results.size();
  end

endmodule

@@ dv/tb_triple_copy_store_with_vote.sv @@
`timescale 1ns / 100ps

module tb_triple_copy_store_with_vote;

  localparam int STORE_DEPTH = 512;
  localparam int COPY_STRIDE = 168;
  localparam int MAX_RUN     = 8;
  localparam int RANDOM_ITEMS = 160;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       action    = tcsv_pkg::ACT_WRITE;
  logic [8:0] address   = '0;
  logic [7:0] data      = '0;
  logic [3:0] count     = '0;
  logic       rsp_stall = 1'b0;
  logic       req_stall;
  logic       rsp_valid;
  logic       kind;
  logic [7:0] read_byte;
  logic [1:0] status;
  logic       last;

  int         mismatch_count;
  int         results_outstanding;
  int         burst_left = 0;
  int         gap_len;
  logic [7:0] stall_phase = '0;

  triple_copy_store_with_vote #(
    .STORE_DEPTH(STORE_DEPTH),
    .COPY_STRIDE(COPY_STRIDE),
    .MAX_RUN    (MAX_RUN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .action   (action),
    .address  (address),
    .data     (data),
    .count    (count),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .kind     (kind),
    .read_byte(read_byte),
    .status   (status),
    .last     (last)
  );

  copy_vote_checker #(
    .STORE_DEPTH(STORE_DEPTH),
    .COPY_STRIDE(COPY_STRIDE),
    .MAX_RUN    (MAX_RUN)
  ) vote_check (
    .clk                (clk),
    .rst                (rst),
    .req_valid          (req_valid),
    .req_stall          (req_stall),
    .action             (action),
    .address            (address),
    .data               (data),
    .count              (count),
    .rsp_valid          (rsp_valid),
    .rsp_stall          (rsp_stall),
    .kind               (kind),
    .read_byte          (read_byte),
    .status             (status),
    .last               (last),
    .mismatch_count     (mismatch_count),
    .results_outstanding(results_outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // The receiver cycles through no stalls, light random, regular and heavy random stalls.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0: rsp_stall <= 1'b0;
      2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2'd2: rsp_stall <= stall_phase[2] & stall_phase[1];
      default: rsp_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Presents one item, holds it until taken, then maybe ends the burst with a gap.
  task automatic send_item(input logic act, input logic [8:0] addr, input logic [7:0] value,
                           input logic [3:0] run_req);
    req_valid <= 1'b1;
    action    <= act;
    address   <= addr;
    data      <= value;
    count     <= run_req;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap_len > 0) begin
        req_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    logic       act;
    logic [8:0] addr;
    logic [3:0] run_req;
    int         pick;

    @(posedge clk);
    while (rst) @(posedge clk);

    // Erased store, write extremes, range rejections, length clipping, runs past the region.
    send_item(tcsv_pkg::ACT_READ,  9'd0,   8'h00, 4'd8);
    send_item(tcsv_pkg::ACT_WRITE, 9'd0,   8'h00, 4'd0);
    send_item(tcsv_pkg::ACT_WRITE, 9'd1,   8'hFF, 4'd15);
    send_item(tcsv_pkg::ACT_WRITE, 9'd2,   8'hA5, 4'd1);
    send_item(tcsv_pkg::ACT_WRITE, 9'd3,   8'h5A, 4'd8);
    send_item(tcsv_pkg::ACT_WRITE, 9'd166, 8'h80, 4'd0);
    send_item(tcsv_pkg::ACT_WRITE, 9'd167, 8'h7F, 4'd0);
    send_item(tcsv_pkg::ACT_WRITE, 9'd168, 8'h11, 4'd0);
    send_item(tcsv_pkg::ACT_WRITE, 9'd511, 8'hEE, 4'd0);
    send_item(tcsv_pkg::ACT_READ,  9'd168, 8'h00, 4'd1);
    send_item(tcsv_pkg::ACT_READ,  9'd511, 8'hFF, 4'd15);
    send_item(tcsv_pkg::ACT_READ,  9'd256, 8'h00, 4'd8);
    send_item(tcsv_pkg::ACT_READ,  9'd0,   8'h00, 4'd0);
    send_item(tcsv_pkg::ACT_READ,  9'd0,   8'h00, 4'd8);
    send_item(tcsv_pkg::ACT_READ,  9'd1,   8'h00, 4'd9);
    send_item(tcsv_pkg::ACT_READ,  9'd0,   8'h00, 4'd15);
    send_item(tcsv_pkg::ACT_READ,  9'd160, 8'h00, 4'd15);
    send_item(tcsv_pkg::ACT_READ,  9'd167, 8'h00, 4'd8);
    send_item(tcsv_pkg::ACT_READ,  9'd167, 8'h00, 4'd1);
    send_item(tcsv_pkg::ACT_WRITE, 9'd100, 8'h3C, 4'd0);
    send_item(tcsv_pkg::ACT_READ,  9'd96,  8'h00, 4'd8);

    // Random traffic, weighted toward both ends of the region; runs at the top cross its end.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      act  = ($urandom_range(0, 99) < 45) ? tcsv_pkg::ACT_WRITE : tcsv_pkg::ACT_READ;
      pick = $urandom_range(0, 99);
      if (pick < 10)
        addr = 9'($urandom_range(COPY_STRIDE, 511));
      else if (pick < 30)
        addr = 9'($urandom_range(0, 7));
      else if (pick < 50)
        addr = 9'($urandom_range(COPY_STRIDE - 8, COPY_STRIDE - 1));
      else
        addr = 9'($urandom_range(0, COPY_STRIDE - 1));
      run_req = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, MAX_RUN));
      send_item(act, addr, 8'($urandom_range(0, 255)), run_req);
    end

    // Drain, then allow a full read time for any stray result.
    req_valid <= 1'b0;
    do @(negedge clk); while (results_outstanding != 0);
    repeat (100) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ triple_copy_store_with_vote.f @@
rtl/tcsv_pkg.sv
rtl/tcsv_ram.sv
rtl/triple_copy_store_with_vote.sv
dv/copy_vote_checker.sv
dv/tb_triple_copy_store_with_vote.sv
